FILE: src/pie_pkg.sv
// ----------------------------------------------------------------------------
// pie_pkg
// Types, constants and arithmetic helpers shared by the pair energy pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pie_pkg;

	localparam int PIE_IN_W  = 232;
	localparam int PIE_OUT_W = 88;
	localparam int PIE_CFG_W = 32;
	localparam int PIE_IDX_W = 3;

	// configuration register indexes
	localparam logic [PIE_IDX_W-1:0] CFG_PERIOD_Y    = 3'd0;
	localparam logic [PIE_IDX_W-1:0] CFG_CUTOFF      = 3'd1;
	localparam logic [PIE_IDX_W-1:0] CFG_WELL_DEPTH  = 3'd2;
	localparam logic [PIE_IDX_W-1:0] CFG_INV_TEMP    = 3'd3;
	localparam logic [PIE_IDX_W-1:0] CFG_SCREENING   = 3'd4;

	localparam logic [63:0] LN2_Q32   = 64'd2977044472;
	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [31:0] period_y;
		logic [31:0] cutoff_ratio;
		logic [31:0] well_depth;
		logic [31:0] inverse_temperature;
		logic [31:0] screening_length;
	} pie_cfg_t;

	localparam pie_cfg_t PIE_CFG_RESET = '{
		period_y:            32'd65536,
		cutoff_ratio:        32'd73562,
		well_depth:          32'd65536,
		inverse_temperature: 32'd65536,
		screening_length:    32'd65536
	};

	// request layout, lowest field in the lowest bits
	typedef struct packed {
		logic        [23:0] second_radius;
		logic        [23:0] first_radius;
		logic signed [15:0] second_charge;
		logic signed [15:0] first_charge;
		logic signed [31:0] second_y;
		logic signed [31:0] second_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_x;
		logic        [9:0]  second_index;
		logic        [9:0]  first_index;
	} pie_in_t;

	typedef struct packed {
		logic        [9:0]  index_a;
		logic        [9:0]  index_b;
		logic signed [63:0] energy;
		logic               sat;
	} pie_res_t;

	// values carried alongside the arithmetic
	typedef struct packed {
		logic        [9:0]  index_a;
		logic        [9:0]  index_b;
		logic        [24:0] s;
		logic signed [31:0] qp;
		logic        [32:0] r;
		logic               zero;
		logic               wca_on;
		logic signed [63:0] elec;
		logic               eflag;
	} pie_side_t;

	typedef struct packed {
		logic [63:0] hh;
		logic [63:0] hl;
		logic [63:0] lh;
		logic [63:0] ll;
	} pie_pp_t;

	typedef struct packed {
		logic        ov;
		logic [63:0] val;
	} pie_mq_t;

	// four 32x32 partial products of a 64x64 product
	function automatic pie_pp_t pie_mul_pp(input logic [63:0] a, input logic [63:0] b);
		pie_pp_t pp;
		pp.hh = {32'd0, a[63:32]} * {32'd0, b[63:32]};
		pp.hl = {32'd0, a[63:32]} * {32'd0, b[31:0]};
		pp.lh = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
		pp.ll = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
		return pp;
	endfunction

	// floor(a*b / 2^32), all ones and ov when it needs more than 64 bits
	function automatic pie_mq_t pie_mul_sum(input pie_pp_t pp);
		logic [127:0] p;
		pie_mq_t      m;
		p = {pp.hh, 64'd0} + {32'd0, pp.hl, 32'd0} + {32'd0, pp.lh, 32'd0} + {64'd0, pp.ll};
		m.ov  = |p[127:96];
		m.val = m.ov ? '1 : p[95:32];
		return m;
	endfunction

	function automatic pie_mq_t pie_to_signed(input logic [63:0] mag, input logic neg);
		pie_mq_t m;
		m.ov = 1'b0;
		if (neg) begin
			if (mag > INT64_MIN) begin
				m.ov  = 1'b1;
				m.val = INT64_MIN;
			end else begin
				m.val = 64'd0 - mag;
			end
		end else if (mag[63]) begin
			m.ov  = 1'b1;
			m.val = INT64_MAX;
		end else begin
			m.val = mag;
		end
		return m;
	endfunction

	// floor(log2 v); zero for v of zero
	function automatic logic [5:0] pie_msb34(input logic [33:0] v);
		logic [5:0] k;
		k = '0;
		for (int i = 0; i < 34; i++) begin
			if (v[i]) begin
				k = 6'(i);
			end
		end
		return k;
	endfunction

	// mantissa aligned to Q1.30
	function automatic logic [30:0] pie_norm(input logic [33:0] v, input logic [5:0] k);
		logic [33:0] w;
		if (k >= 6'd30) begin
			w = v >> (k - 6'd30);
		end else begin
			w = v << (6'd30 - k);
		end
		return w[30:0];
	endfunction

	// one fraction bit of log2: square, renormalise; bit in the msb
	function automatic logic [31:0] pie_sq_step(input logic [30:0] m);
		logic [61:0] p;
		p = {31'd0, m} * {31'd0, m};
		if (p[61]) begin
			return {1'b1, p[61:31]};
		end else begin
			return {1'b0, p[60:30]};
		end
	endfunction

endpackage

`default_nettype wire

FILE: src/pie_core.sv
// ----------------------------------------------------------------------------
// pie_core
// Pair energy arithmetic pipeline, 181 stages, one request per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  pie_pkg::pie_in_t  in_item,
	input  pie_pkg::pie_cfg_t cfg,
	output logic              out_valid,
	output pie_pkg::pie_res_t out_res
);
	import pie_pkg::*;

	localparam int MOD_N  = 33;
	localparam int SQRT_N = 32;
	localparam int LOG_N  = 32;
	localparam int DIV_N  = 57;
	localparam int LAT    = 181;

	// valid bits
	logic [LAT-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_s[LAT-1];

	// stage 1: differences, contact distance, charge product
	logic [32:0] dx_c, dy_c;
	pie_side_t   sd_c;

	always_comb begin
		dx_c = {in_item.first_x[31], in_item.first_x} - {in_item.second_x[31], in_item.second_x};
		dy_c = {in_item.first_y[31], in_item.first_y} - {in_item.second_y[31], in_item.second_y};
		sd_c         = '0;
		sd_c.index_a = in_item.first_index;
		sd_c.index_b = in_item.second_index;
		sd_c.s       = {1'b0, in_item.first_radius} + {1'b0, in_item.second_radius};
		sd_c.qp      = in_item.first_charge * in_item.second_charge;
	end

	// |dy| mod period_y, one bit a stage
	logic [31:0] md_rem_s [MOD_N+1];
	logic [32:0] md_ax_s  [MOD_N+1];
	logic [32:0] md_ay_s  [MOD_N+1];
	pie_side_t   md_sd_s  [MOD_N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			md_rem_s[0] <= '0;
			md_ax_s[0]  <= dx_c[32] ? -dx_c : dx_c;
			md_ay_s[0]  <= dy_c[32] ? -dy_c : dy_c;
			md_sd_s[0]  <= sd_c;
		end
	end

	for (genvar k = 1; k <= MOD_N; k++) begin : g_mod
		logic [32:0] t, d;
		always_comb begin
			t = {md_rem_s[k-1], md_ay_s[k-1][MOD_N-k]};
			d = t - {1'b0, cfg.period_y};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				md_rem_s[k] <= (t >= {1'b0, cfg.period_y}) ? d[31:0] : t[31:0];
				md_ax_s[k]  <= md_ax_s[k-1];
				md_ay_s[k]  <= md_ay_s[k-1];
				md_sd_s[k]  <= md_sd_s[k-1];
			end
		end
	end

	// stage 35: nearest image
	logic [32:0] ax_s35, ay_s35;
	pie_side_t   sd_s35;
	logic [31:0] rem_c;

	assign rem_c = md_rem_s[MOD_N];

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s35 <= md_ax_s[MOD_N];
			sd_s35 <= md_sd_s[MOD_N];
			if (cfg.period_y == '0) begin
				ay_s35 <= md_ay_s[MOD_N];
			end else if ({rem_c, 1'b0} >= {1'b0, cfg.period_y}) begin
				ay_s35 <= {1'b0, cfg.period_y - rem_c};
			end else begin
				ay_s35 <= {1'b0, rem_c};
			end
		end
	end

	// stage 36: squares, halved when either side reaches 2^31
	logic        sh_c, sh_s36;
	logic [31:0] opx_c, opy_c;
	logic [63:0] sqx_s36, sqy_s36;
	pie_side_t   sd_s36;

	always_comb begin
		sh_c  = (|ax_s35[32:31]) | (|ay_s35[32:31]);
		opx_c = sh_c ? ax_s35[32:1] : ax_s35[31:0];
		opy_c = sh_c ? ay_s35[32:1] : ay_s35[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s36 <= {32'd0, opx_c} * {32'd0, opx_c};
			sqy_s36 <= {32'd0, opy_c} * {32'd0, opy_c};
			sh_s36  <= sh_c;
			sd_s36  <= sd_s35;
		end
	end

	// integer square root, one result bit a stage
	logic [63:0] sq_v_s   [SQRT_N+1];
	logic [63:0] sq_res_s [SQRT_N+1];
	logic        sq_sh_s  [SQRT_N+1];
	pie_side_t   sq_sd_s  [SQRT_N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_v_s[0]   <= sqx_s36 + sqy_s36;
			sq_res_s[0] <= '0;
			sq_sh_s[0]  <= sh_s36;
			sq_sd_s[0]  <= sd_s36;
		end
	end

	for (genvar j = 1; j <= SQRT_N; j++) begin : g_sqrt
		localparam logic [63:0] BITC = 64'd1 << (64 - 2*j);
		logic [63:0] tsum;
		logic        ge;
		always_comb begin
			tsum = sq_res_s[j-1] + BITC;
			ge   = sq_v_s[j-1] >= tsum;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_v_s[j]   <= ge ? sq_v_s[j-1] - tsum : sq_v_s[j-1];
				sq_res_s[j] <= ge ? (sq_res_s[j-1] >> 1) + BITC : sq_res_s[j-1] >> 1;
				sq_sh_s[j]  <= sq_sh_s[j-1];
				sq_sd_s[j]  <= sq_sd_s[j-1];
			end
		end
	end

	// stage 70: distance, cutoff product
	logic [31:0] root_c;
	logic [32:0] r_c;
	logic [56:0] mc_s70;
	pie_side_t   sd70_c, sd_s70;

	always_comb begin
		root_c      = sq_res_s[SQRT_N][31:0];
		r_c         = sq_sh_s[SQRT_N] ? {root_c, 1'b0} : {1'b0, root_c};
		sd70_c      = sq_sd_s[SQRT_N];
		sd70_c.r    = r_c;
		sd70_c.zero = (r_c == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s70 <= sd70_c;
			mc_s70 <= {25'd0, cfg.cutoff_ratio} * {32'd0, sq_sd_s[SQRT_N].s};
		end
	end

	// stages 71..73: log arguments, exponents, mantissas
	logic [33:0] va_s71, vb_s71, va_s72, vb_s72;
	logic [5:0]  ka_s72, kb_s72;
	pie_side_t   sd71_c, sd_s71, sd_s72;

	always_comb begin
		sd71_c        = sd_s70;
		sd71_c.wca_on = ({8'd0, sd_s70.r, 16'd0} < mc_s70) && (cfg.well_depth != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			va_s71 <= {1'b0, sd_s70.r} + {2'b0, cfg.screening_length};
			vb_s71 <= {1'b0, sd_s70.r};
			sd_s71 <= sd71_c;
			va_s72 <= va_s71;
			vb_s72 <= vb_s71;
			ka_s72 <= pie_msb34(va_s71);
			kb_s72 <= pie_msb34(vb_s71);
			sd_s72 <= sd_s71;
		end
	end

	// log2 fraction bits, one squaring a stage for each argument
	logic [30:0] lg_ma_s [LOG_N+1];
	logic [30:0] lg_mb_s [LOG_N+1];
	logic [31:0] lg_fa_s [LOG_N+1];
	logic [31:0] lg_fb_s [LOG_N+1];
	logic [5:0]  lg_ka_s [LOG_N+1];
	logic [5:0]  lg_kb_s [LOG_N+1];
	pie_side_t   lg_sd_s [LOG_N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			lg_ma_s[0] <= pie_norm(va_s72, ka_s72);
			lg_mb_s[0] <= pie_norm(vb_s72, kb_s72);
			lg_fa_s[0] <= '0;
			lg_fb_s[0] <= '0;
			lg_ka_s[0] <= ka_s72;
			lg_kb_s[0] <= kb_s72;
			lg_sd_s[0] <= sd_s72;
		end
	end

	for (genvar i = 1; i <= LOG_N; i++) begin : g_log
		logic [31:0] sa, sb;
		always_comb begin
			sa = pie_sq_step(lg_ma_s[i-1]);
			sb = pie_sq_step(lg_mb_s[i-1]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				lg_ma_s[i] <= sa[30:0];
				lg_mb_s[i] <= sb[30:0];
				lg_fa_s[i] <= {lg_fa_s[i-1][30:0], sa[31]};
				lg_fb_s[i] <= {lg_fb_s[i-1][30:0], sb[31]};
				lg_ka_s[i] <= lg_ka_s[i-1];
				lg_kb_s[i] <= lg_kb_s[i-1];
				lg_sd_s[i] <= lg_sd_s[i-1];
			end
		end
	end

	// stage 106: log difference, coupling
	logic [37:0] la_c, lb_c, d_s106;
	logic [31:0] qabs_c;
	logic [62:0] c_s106;
	pie_side_t   sd_s106;

	always_comb begin
		la_c   = {lg_ka_s[LOG_N], lg_fa_s[LOG_N]};
		lb_c   = {lg_kb_s[LOG_N], lg_fb_s[LOG_N]};
		qabs_c = lg_sd_s[LOG_N].qp[31] ? -lg_sd_s[LOG_N].qp : lg_sd_s[LOG_N].qp;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s106  <= (la_c > lb_c) ? la_c - lb_c : '0;
			c_s106  <= {32'd0, qabs_c[30:0]} * {31'd0, cfg.inverse_temperature};
			sd_s106 <= lg_sd_s[LOG_N];
		end
	end

	// stages 107..111: ln, electrostatic term
	pie_pp_t     pp_s107, pp_s109;
	pie_mq_t     lnv_s108, em_s110;
	logic [62:0] c_s107, c_s108;
	logic        ov_s109, ov_s110;
	pie_side_t   sd_s107, sd_s108, sd_s109, sd_s110;
	pie_mq_t     ts_c;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s107  <= pie_mul_pp({26'd0, d_s106}, LN2_Q32);
			c_s107   <= c_s106;
			sd_s107  <= sd_s106;
			lnv_s108 <= pie_mul_sum(pp_s107);
			c_s108   <= c_s107;
			sd_s108  <= sd_s107;
			pp_s109  <= pie_mul_pp({1'b0, c_s108}, lnv_s108.val);
			ov_s109  <= lnv_s108.ov;
			sd_s109  <= sd_s108;
			em_s110  <= pie_mul_sum(pp_s109);
			ov_s110  <= ov_s109;
			sd_s110  <= sd_s109;
		end
	end

	assign ts_c = pie_to_signed(em_s110.val, sd_s110.qp[31]);

	// division s*2^32 / r, one quotient bit a stage
	logic [32:0] dv_rem_s [DIV_N+1];
	logic [56:0] dv_q_s   [DIV_N+1];
	pie_side_t   dv_sd_s  [DIV_N+1];
	pie_side_t   dv0_c;

	always_comb begin
		dv0_c = sd_s110;
		if (cfg.screening_length != '0) begin
			dv0_c.elec  = ts_c.val;
			dv0_c.eflag = ov_s110 | em_s110.ov | ts_c.ov;
		end else begin
			dv0_c.elec  = '0;
			dv0_c.eflag = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= '0;
			dv_q_s[0]   <= '0;
			dv_sd_s[0]  <= dv0_c;
		end
	end

	for (genvar k = 1; k <= DIV_N; k++) begin : g_div
		localparam int B = DIV_N - k;
		logic        dbit;
		logic [33:0] t, d;
		logic        ge;
		if (B >= 32) begin : g_hi
			assign dbit = dv_sd_s[k-1].s[B-32];
		end else begin : g_lo
			assign dbit = 1'b0;
		end
		always_comb begin
			t  = {dv_rem_s[k-1], dbit};
			d  = t - {1'b0, dv_sd_s[k-1].r};
			ge = t >= {1'b0, dv_sd_s[k-1].r};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[k] <= ge ? d[32:0] : t[32:0];
				dv_q_s[k]   <= {dv_q_s[k-1][55:0], ge};
				dv_sd_s[k]  <= dv_sd_s[k-1];
			end
		end
	end

	// stages 169..176: powers of s/r
	pie_pp_t     pp_s169, pp_s171, pp_s173, pp_s175;
	pie_mq_t     t2_c, t4_c, t6_c, t12_c;
	logic [63:0] t2_s170, t2_s171, t2_s172, t4_s172, t6_s174, t6_s175, t6_s176, t12_s176;
	logic        pov_s170, pov_s171, pov_s172, pov_s173, pov_s174, pov_s175, pov_s176;
	pie_side_t   sd_s169, sd_s170, sd_s171, sd_s172, sd_s173, sd_s174, sd_s175, sd_s176;

	always_comb begin
		t2_c  = pie_mul_sum(pp_s169);
		t4_c  = pie_mul_sum(pp_s171);
		t6_c  = pie_mul_sum(pp_s173);
		t12_c = pie_mul_sum(pp_s175);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s169  <= pie_mul_pp({7'd0, dv_q_s[DIV_N]}, {7'd0, dv_q_s[DIV_N]});
			sd_s169  <= dv_sd_s[DIV_N];
			t2_s170  <= t2_c.val;
			pov_s170 <= t2_c.ov;
			sd_s170  <= sd_s169;
			pp_s171  <= pie_mul_pp(t2_s170, t2_s170);
			t2_s171  <= t2_s170;
			pov_s171 <= pov_s170;
			sd_s171  <= sd_s170;
			t4_s172  <= t4_c.val;
			t2_s172  <= t2_s171;
			pov_s172 <= pov_s171 | t4_c.ov;
			sd_s172  <= sd_s171;
			pp_s173  <= pie_mul_pp(t4_s172, t2_s172);
			pov_s173 <= pov_s172;
			sd_s173  <= sd_s172;
			t6_s174  <= t6_c.val;
			pov_s174 <= pov_s173 | t6_c.ov;
			sd_s174  <= sd_s173;
			pp_s175  <= pie_mul_pp(t6_s174, t6_s174);
			t6_s175  <= t6_s174;
			pov_s175 <= pov_s174;
			sd_s175  <= sd_s174;
			t12_s176 <= t12_c.val;
			t6_s176  <= t6_s175;
			pov_s176 <= pov_s175 | t12_c.ov;
			sd_s176  <= sd_s175;
		end
	end

	// stages 177..180: repulsion term
	logic [63:0] dd_s177;
	logic        neg_s177, neg_s178, neg_s179;
	logic        pov_s177, pov_s178, pov_s179;
	pie_pp_t     pp_s178;
	pie_mq_t     wm_s179;
	pie_side_t   sd_s177, sd_s178, sd_s179, sd_s180;
	logic [63:0] wm4_c, wca_s180, wca_c;
	logic        wf_c, wf_s180;
	pie_mq_t     ws_c;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s177 <= t12_s176 < t6_s176;
			dd_s177  <= (t12_s176 < t6_s176) ? t6_s176 - t12_s176 : t12_s176 - t6_s176;
			pov_s177 <= pov_s176;
			sd_s177  <= sd_s176;
			pp_s178  <= pie_mul_pp({16'd0, cfg.well_depth, 16'd0}, dd_s177);
			neg_s178 <= neg_s177;
			pov_s178 <= pov_s177;
			sd_s178  <= sd_s177;
			wm_s179  <= pie_mul_sum(pp_s178);
			neg_s179 <= neg_s178;
			pov_s179 <= pov_s178;
			sd_s179  <= sd_s178;
		end
	end

	always_comb begin
		wm4_c = (|wm_s179.val[63:62]) ? '1 : {wm_s179.val[61:0], 2'b00};
		ws_c  = pie_to_signed(wm4_c, neg_s179);
		if (!sd_s179.wca_on) begin
			wca_c = '0;
			wf_c  = 1'b0;
		end else if (pov_s179) begin
			wca_c = INT64_MAX;
			wf_c  = 1'b1;
		end else begin
			wca_c = ws_c.val;
			wf_c  = wm_s179.ov | (|wm_s179.val[63:62]) | ws_c.ov;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wca_s180 <= wca_c;
			wf_s180  <= wf_c;
			sd_s180  <= sd_s179;
		end
	end

	// stage 181: saturating sum
	logic [64:0] sum_c;
	logic        hi_c, lo_c;

	always_comb begin
		sum_c = {wca_s180[63], wca_s180} + {sd_s180.elec[63], sd_s180.elec};
		hi_c  = !sum_c[64] && sum_c[63];
		lo_c  = sum_c[64] && !sum_c[63];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res.index_a <= sd_s180.index_a;
			out_res.index_b <= sd_s180.index_b;
			if (sd_s180.zero) begin
				out_res.energy <= INT64_MAX;
				out_res.sat    <= 1'b1;
			end else begin
				out_res.energy <= hi_c ? INT64_MAX : (lo_c ? INT64_MIN : sum_c[63:0]);
				out_res.sat    <= hi_c | lo_c | wf_s180 | sd_s180.eflag;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/pair_interaction_energy.sv
// Path: the 181-stage arithmetic pipeline plus the output register.
// Throughput: one request per cycle while s_axis_tready is high; the
// longest sections are the 57-stage quotient divider, the 33-stage modulo,
// the 32-stage root and log units.
// Reset: arst_n clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// pair_interaction_energy
// Pair energy: WCA repulsion plus screened log electrostatics, streaming.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_interaction_energy (
	input  logic                          clk,
	input  logic                          arst_n,
	// first_index, second_index, first_x, first_y, second_x, second_y,
	// first_charge, second_charge, first_radius, second_radius, zero pad
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [pie_pkg::PIE_IN_W-1:0]  s_axis_tdata,
	// pair_index_a, pair_index_b, pair_energy, zero pad
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [pie_pkg::PIE_OUT_W-1:0] m_axis_tdata,
	// saturated
	output logic [0:0]                    m_axis_tuser,
	input  logic                          cfg_wr_en,
	input  logic [pie_pkg::PIE_IDX_W-1:0] cfg_index,
	input  logic [pie_pkg::PIE_CFG_W-1:0] cfg_data
);
	import pie_pkg::*;

	// configuration, written only while block is idle: unchecked user rule
	pie_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= PIE_CFG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PERIOD_Y:   cfg_q.period_y            <= cfg_data;
				CFG_CUTOFF:     cfg_q.cutoff_ratio        <= cfg_data;
				CFG_WELL_DEPTH: cfg_q.well_depth          <= cfg_data;
				CFG_INV_TEMP:   cfg_q.inverse_temperature <= cfg_data;
				CFG_SCREENING:  cfg_q.screening_length    <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the skid slot is free; with the output register
	// that gives two result slots, so one waiting result never stops intake
	logic     en;
	logic     core_valid;
	pie_res_t core_res;
	logic     out_v_q, skid_v_q;
	pie_res_t out_q, skid_q;
	logic     push, pop;

	assign en            = !skid_v_q;
	assign s_axis_tready = en;
	assign push          = core_valid & en;
	assign pop           = out_v_q & m_axis_tready;

	pie_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_item   (pie_in_t'(s_axis_tdata[227:0])),
		.cfg       (cfg_q),
		.out_valid (core_valid),
		.out_res   (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || pop) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || pop) begin
			out_q <= core_res;
		end else if (push) begin
			skid_q <= core_res;
		end
	end

	assign m_axis_tvalid   = out_v_q;
	assign m_axis_tdata    = {4'd0, out_q.energy, out_q.index_b, out_q.index_a};
	assign m_axis_tuser[0] = out_q.sat;

endmodule

`default_nettype wire

FILE: bench/tb_pair_interaction_energy.sv
// ----------------------------------------------------------------------------
// tb_pair_interaction_energy
// Self-checking bench for the pair energy pipeline. Pair requests are streamed
// in bursts against a stalling result sink. Every accepted request is run
// through a bit-exact model of the fixed point maths and checked in order
// against the returned energy, tags and saturation flag, across several
// register settings including the extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pair_interaction_energy;
	import pie_pkg::*;

	localparam int DRAIN_CYCLES = 220;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic [9:0]         first_index;
		logic [9:0]         second_index;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [15:0] first_charge;
		logic signed [15:0] second_charge;
		logic [23:0]        first_radius;
		logic [23:0]        second_radius;
	} pair_req_t;

	typedef struct {
		logic [9:0]         index_a;
		logic [9:0]         index_b;
		logic signed [63:0] energy;
		logic               sat;
	} pair_energy_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [PIE_IN_W-1:0]  s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [PIE_OUT_W-1:0] m_axis_tdata;
	logic [0:0]           m_axis_tuser;
	logic                 cfg_wr_en;
	logic [PIE_IDX_W-1:0] cfg_index;
	logic [PIE_CFG_W-1:0] cfg_data;

	pair_interaction_energy dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// bench copy of the register file
	logic [31:0] m_period, m_cutoff, m_eps, m_invt, m_xsi;

	pair_energy_t energy_q[$];
	int           n_sent, n_checked, n_errors, n_sat, n_cfg;
	int           burst_left;
	int           cycles;

	// ---------------------------------------------------------------- clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------ fixed point maths
	// floor(a*b / 2^32), saturating with overflow flag
	function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b,
			inout logic ov);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		if (|p[127:96]) begin
			ov = 1'b1;
			return '1;
		end
		return p[95:32];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, bit_v;
		res   = '0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v   = v - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// log2 in Q.32 for v >= 1
	function automatic logic [63:0] log2_q32(input logic [63:0] v);
		int          k;
		logic [63:0] mant, frac;
		k    = 0;
		frac = '0;
		while (k < 63 && (v >> (k + 1)) != 0) k++;
		mant = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
		for (int i = 0; i < 32; i++) begin
			mant = (mant * mant) >> 30;
			frac = frac << 1;
			if (mant >= (64'd1 << 31)) begin
				frac = frac | 64'd1;
				mant = mant >> 1;
			end
		end
		return (64'(k) << 32) | frac;
	endfunction

	function automatic logic signed [63:0] apply_sign(input logic [63:0] mag, input logic neg,
			inout logic ov);
		if (neg) begin
			if (mag > INT64_MIN) begin
				ov = 1'b1;
				return INT64_MIN;
			end
			return 64'd0 - mag;
		end
		if (mag[63]) begin
			ov = 1'b1;
			return INT64_MAX;
		end
		return mag;
	endfunction

	function automatic pair_energy_t pair_energy_of(input pair_req_t p);
		pair_energy_t       res;
		logic signed [63:0] dx, dy, wca, elec, qp;
		logic [63:0]        ax, ay, rem, r, s, t, t2, t4, t6, t12, d, wm, la, lb, lnv, c, em;
		logic               flag, pov, neg;
		res.index_a = p.first_index;
		res.index_b = p.second_index;
		flag = 1'b0;
		wca  = '0;
		elec = '0;
		s  = 64'(p.first_radius) + 64'(p.second_radius);
		dx = 64'(p.first_x) - 64'(p.second_x);
		dy = 64'(p.first_y) - 64'(p.second_y);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		// nearest periodic image in y; a zero period disables wrapping
		if (m_period != 0) begin
			rem = ay % 64'(m_period);
			ay  = (2 * rem >= 64'(m_period)) ? 64'(m_period) - rem : rem;
		end
		if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
			ax = ax >> 1;
			ay = ay >> 1;
			r  = int_sqrt(ax * ax + ay * ay) << 1;
		end else begin
			r = int_sqrt(ax * ax + ay * ay);
		end
		if (r == 0) begin
			res.energy = INT64_MAX;
			res.sat    = 1'b1;
			return res;
		end
		// repulsion only inside the cutoff and for non-zero depth
		if ((r << 16) < 64'(m_cutoff) * s && m_eps != 0) begin
			pov = 1'b0;
			t   = (s << 32) / r;
			t2  = mul_q32(t, t, pov);
			t4  = mul_q32(t2, t2, pov);
			t6  = mul_q32(t4, t2, pov);
			t12 = mul_q32(t6, t6, pov);
			if (pov) begin
				flag = 1'b1;
				wca  = INT64_MAX;
			end else begin
				neg = t12 < t6;
				d   = neg ? t6 - t12 : t12 - t6;
				wm  = mul_q32(64'(m_eps) << 16, d, flag);
				if (wm > (64'hFFFF_FFFF_FFFF_FFFF >> 2)) begin
					flag = 1'b1;
					wm   = '1;
				end else begin
					wm = wm << 2;
				end
				wca = apply_sign(wm, neg, flag);
			end
		end
		if (m_xsi != 0) begin
			la   = log2_q32(r + 64'(m_xsi));
			lb   = log2_q32(r);
			d    = la > lb ? la - lb : 64'd0;
			lnv  = mul_q32(d, LN2_Q32, flag);
			qp   = 64'(p.first_charge) * 64'(p.second_charge);
			c    = (qp < 0 ? -qp : qp) * 64'(m_invt);
			em   = mul_q32(c, lnv, flag);
			elec = apply_sign(em, qp < 0, flag);
		end
		if (elec > 0 && wca > $signed(INT64_MAX) - elec) begin
			flag       = 1'b1;
			res.energy = INT64_MAX;
		end else if (elec < 0 && wca < $signed(INT64_MIN) - elec) begin
			flag       = 1'b1;
			res.energy = INT64_MIN;
		end else begin
			res.energy = wca + elec;
		end
		res.sat = flag;
		return res;
	endfunction

	// ---------------------------------------------------------- result sink
	// stall pattern rotates: free running, light, heavy
	always @(negedge clk) begin
		case ((cycles >> 8) % 3)
			0: begin
				m_axis_tready <= 1'b1;
			end
			1: begin
				m_axis_tready <= ($urandom_range(0, 9) < 7);
			end
			default: begin
				m_axis_tready <= ($urandom_range(0, 9) < 2);
			end
		endcase
	end

	always @(posedge clk) begin
		pair_energy_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (energy_q.size() == 0) begin
				$error("unexpected result, nothing outstanding");
				n_errors++;
			end else begin
				want = energy_q.pop_front();
				n_checked++;
				if (want.sat) n_sat++;
				if (m_axis_tdata[9:0] !== want.index_a) begin
					$error("pair_index_a: expected %0d, got %0d", want.index_a,
						m_axis_tdata[9:0]);
					n_errors++;
				end
				if (m_axis_tdata[19:10] !== want.index_b) begin
					$error("pair_index_b: expected %0d, got %0d", want.index_b,
						m_axis_tdata[19:10]);
					n_errors++;
				end
				if (m_axis_tdata[83:20] !== want.energy) begin
					$error("pair_energy: expected %0d, got %0d", want.energy,
						$signed(m_axis_tdata[83:20]));
					n_errors++;
				end
				if (m_axis_tuser[0] !== want.sat) begin
					$error("saturated: expected %0b, got %0b", want.sat, m_axis_tuser[0]);
					n_errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------- drivers
	// one request; the sender runs in random bursts separated by random gaps
	task automatic send_pair(input pair_req_t p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, p.second_radius, p.first_radius, p.second_charge,
			p.first_charge, p.second_y, p.second_x, p.first_y, p.first_x,
			p.second_index, p.first_index};
		do @(posedge clk); while (!s_axis_tready);
		energy_q.push_back(pair_energy_of(p));
		n_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (energy_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// enable stays high across back-to-back writes; load_regs drops it
	task automatic write_reg(input logic [PIE_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		case (idx)
			CFG_PERIOD_Y:   m_period = val;
			CFG_CUTOFF:     m_cutoff = val;
			CFG_WELL_DEPTH: m_eps    = val;
			CFG_INV_TEMP:   m_invt   = val;
			default:        m_xsi    = val;
		endcase
		n_cfg++;
	endtask

	task automatic load_regs(input logic [31:0] period, input logic [31:0] cutoff,
			input logic [31:0] eps, input logic [31:0] invt, input logic [31:0] xsi);
		wait_idle();
		write_reg(CFG_PERIOD_Y, period);
		write_reg(CFG_CUTOFF, cutoff);
		write_reg(CFG_WELL_DEPTH, eps);
		write_reg(CFG_INV_TEMP, invt);
		write_reg(CFG_SCREENING, xsi);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic pair_req_t make_pair(input logic signed [31:0] x1,
			input logic signed [31:0] y1, input logic signed [31:0] x2,
			input logic signed [31:0] y2, input logic signed [15:0] q1,
			input logic signed [15:0] q2, input logic [23:0] r1, input logic [23:0] r2);
		pair_req_t p;
		p.first_index   = 10'($urandom);
		p.second_index  = 10'($urandom);
		p.first_x       = x1;
		p.first_y       = y1;
		p.second_x      = x2;
		p.second_y      = y2;
		p.first_charge  = q1;
		p.second_charge = q2;
		p.first_radius  = r1;
		p.second_radius = r2;
		return p;
	endfunction

	// mostly near pairs at assorted scales, some fully random noise
	function automatic pair_req_t random_pair();
		pair_req_t          p;
		logic signed [31:0] x1, y1;
		int                 sh;
		sh = $urandom_range(0, 31);
		x1 = $signed($urandom) >>> sh;
		y1 = $signed($urandom) >>> sh;
		p  = make_pair(x1, y1, x1 + ($signed($urandom) >>> $urandom_range(8, 31)),
			y1 + ($signed($urandom) >>> $urandom_range(8, 31)),
			16'($signed($urandom) >>> $urandom_range(0, 15)),
			16'($signed($urandom) >>> $urandom_range(0, 15)),
			24'($urandom >> $urandom_range(8, 31)), 24'($urandom >> $urandom_range(8, 31)));
		if ($urandom_range(0, 9) == 0) begin
			p = make_pair($signed($urandom), $signed($urandom), $signed($urandom),
				$signed($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
				24'($urandom));
		end
		if ($urandom_range(0, 31) == 0) p.second_index = p.first_index;
		return p;
	endfunction

	// ---------------------------------------------------------------- tests
	// extremes of every field under the current register settings
	task automatic test_field_extremes();
		pair_req_t p;
		p = make_pair(0, 0, 0, 0, 16'sh0100, 16'sh0100, 24'h010000, 24'h010000);
		p.first_index  = 10'd0;
		p.second_index = 10'd1023;
		send_pair(p);     // zero distance
		p = make_pair(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
			16'sh7FFF, 16'sh8000, 24'hFFFFFF, 24'hFFFFFF);
		p.first_index  = 10'd1023;
		p.second_index = 10'd0;
		send_pair(p);     // widest separation, halved before the root
		send_pair(make_pair(32'sh80000000, 0, 32'sh7FFFFFFF, 0, 16'sh8000, 16'sh8000,
			24'd0, 24'd0));
		send_pair(make_pair(0, 0, 32'sh00010000, 0, 16'sh7FFF, 16'sh7FFF,
			24'h008000, 24'h008000));   // contact distance
		send_pair(make_pair(0, 0, 1, 0, 16'sh0100, 16'shFF00,
			24'hFFFFFF, 24'hFFFFFF));   // tiny r, huge s: powers overflow
		send_pair(make_pair(0, 0, 32'sh00011000, 0, 16'sh0200, 16'sh0300,
			24'h008000, 24'h008000));   // just inside cutoff
		send_pair(make_pair(0, 0, 32'sh00030000, 0, 16'sh0200, 16'shFD00,
			24'h008000, 24'h008000));   // outside cutoff
		p = make_pair(5, 7, 5, 7, 0, 0, 24'h000001, 0);
		p.second_index = p.first_index;
		send_pair(p);     // equal tags
	endtask

	// y separation near multiples of the period
	task automatic test_wrap();
		send_pair(make_pair(0, 0, 0, 32'sh00008000, 16'sh0100, 16'sh0100, 24'h004000,
			24'h004000));
		send_pair(make_pair(0, 0, 0, 32'sh00010000, 16'sh0100, 16'sh0100, 24'h004000,
			24'h004000));
		send_pair(make_pair(0, 32'sh00027FFF, 0, 0, 16'sh0100, 16'shFF00, 24'h004000,
			24'h004000));
		send_pair(make_pair(0, 32'sh7FFFFFFF, 0, 32'sh80000000, 16'sh0100, 16'sh0100,
			24'h004000, 24'h004000));
	endtask

	// register extremes: zero period, zero depth, zero screening, all ones
	task automatic test_register_extremes();
		load_regs(32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		test_field_extremes();
		test_wrap();
		load_regs(32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
		test_field_extremes();
		load_regs(32'hFFFFFFFF, 32'd73562, 32'd0, 32'd65536, 32'd0);
		test_wrap();
	endtask

	task automatic test_random(input int count);
		repeat (count) send_pair(random_pair());
	endtask

	// random pairs under a spread of settings
	task automatic test_random_settings();
		load_regs(32'd65536, 32'd73562, 32'd65536, 32'd65536, 32'd65536);
		test_random(400);
		load_regs(32'h00050000, 32'h00020000, 32'h00000100, 32'h00100000, 32'h00004000);
		test_random(300);
		load_regs(32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		test_random(250);
		load_regs(32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
		test_random(150);
		for (int k = 0; k < 5; k++) begin
			load_regs($urandom >> $urandom_range(0, 16), $urandom >> $urandom_range(8, 20),
				$urandom >> $urandom_range(0, 24), $urandom >> $urandom_range(0, 24),
				$urandom >> $urandom_range(0, 24));
			test_random(140);
		end
	endtask

	// ----------------------------------------------------------------- main
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = CFG_PERIOD_Y;
		cfg_data      = '0;
		cycles        = 0;
		n_sent        = 0;
		n_checked     = 0;
		n_errors      = 0;
		n_sat         = 0;
		n_cfg         = 0;
		burst_left    = 0;
		m_period      = PIE_CFG_RESET.period_y;
		m_cutoff      = PIE_CFG_RESET.cutoff_ratio;
		m_eps         = PIE_CFG_RESET.well_depth;
		m_invt        = PIE_CFG_RESET.inverse_temperature;
		m_xsi         = PIE_CFG_RESET.screening_length;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_field_extremes();    // reset defaults
		test_wrap();
		test_register_extremes();
		test_random_settings();

		wait_idle();
		$display("pair requests sent %0d, results checked %0d (%0d saturated)",
			n_sent, n_checked, n_sat);
		$display("register writes %0d, mismatches %0d", n_cfg, n_errors);
		if (n_errors == 0 && energy_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
src/pie_pkg.sv
src/pie_core.sv
src/pair_interaction_energy.sv
bench/tb_pair_interaction_energy.sv
